// ===== rtl/sblur_pkg.sv =====
`default_nettype none

package sblur_pkg;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_MULT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_SHIFT  = 2'd2;

  // Register reset values
  localparam logic [5:0] RADIUS_RST     = 6'd1;
  localparam logic [9:0] NORM_MULT_RST  = 10'd512;
  localparam logic [4:0] NORM_SHIFT_RST = 5'd11;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // Incoming pixel item
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       line_end;
  } pix_in_t;

  // Blurred pixel item
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       run_last;
    logic       line_last;
  } pix_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SB_IDLE,
    SB_SWEEP,
    SB_DRAIN,
    SB_MUL,
    SB_EMIT
  } sb_state_t;

endpackage

`default_nettype wire

// ===== rtl/stack_blur_line_pass_unit.sv =====
`default_nettype none

// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-------------------------------
// input    | in_valid, in_stall, in_data             | one RGBA pixel item, line_end
// result   | out_valid, out_stall, out_data          | one blurred pixel item
// config   | cfg_valid, cfg_ready, cfg_index, cfg_wdata | register write, always ready
//
// An item is taken and written into the window ring memory. Each result then
// sweeps the ring once, one read per cycle over the 2r+1 window, followed by
// the read drain, normalising multiply and output load steps. A flagged last
// pixel gives up to r+1 results in a row. Reset is synchronous; the ring
// memory is not cleared, reads stay within pixels written in the current
// line. The input stalls while results are being worked; a held result in
// the output register stalls only its load.

module stack_blur_line_pass_unit #(
  parameter int unsigned MAX_RADIUS = 63
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  // pixel input
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire sblur_pkg::pix_in_t                  in_data,
  // blurred output
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output sblur_pkg::pix_out_t                      out_data,
  // configuration writes
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire [sblur_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [sblur_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int unsigned RingDepth = 2 * MAX_RADIUS + 1;
  localparam int unsigned AW   = $clog2(RingDepth);
  localparam int unsigned CW   = $clog2(RingDepth + 1);
  localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned XW   = AW + 1;
  localparam int unsigned WW   = RW + 1;
  localparam int unsigned SumW = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) * 255 + 1);
  localparam int unsigned PrdW = SumW + 10;

  // Window ring memory
  logic [31:0] ring_mem [RingDepth];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] rd_slot;

  // State and registers
  sblur_pkg::sb_state_t state_r, state_nxt;
  logic [AW-1:0]   wpos_r, wpos_nxt;
  logic [CW-1:0]   seen_r, seen_nxt;
  logic [5:0]      radius_r, radius_nxt;
  logic [9:0]      mult_r, mult_nxt;
  logic [4:0]      shift_r, shift_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [RW-1:0]   c_r, c_nxt;
  logic            last_mode_r, last_mode_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [WW-1:0]   rd_w_r, rd_w_nxt;
  logic            rd_ctr_r, rd_ctr_nxt;
  logic [7:0]      alpha_r, alpha_nxt;
  logic [SumW-1:0] acc_r [3];
  logic [SumW-1:0] acc_nxt [3];
  logic [PrdW-1:0] prod_r [3];
  logic [PrdW-1:0] prod_nxt [3];
  logic            out_valid_r, out_valid_nxt;
  sblur_pkg::pix_out_t out_data_r, out_data_nxt;

  // Combinational helpers
  logic            accept;
  logic            out_free;
  logic [RW-1:0]   r_eff;
  logic [CW-1:0]   seen_inc;
  logic [CW-1:0]   oldest;
  logic [XW-1:0]   cr_sum;
  logic [XW-1:0]   age_raw;
  logic [AW-1:0]   age;
  logic [XW-1:0]   slot_sum;
  logic [AW-1:0]   tap_off;
  logic [WW-1:0]   weight;
  logic [RW-1:0]   c_start;
  logic            start_res;
  logic            sweep_done;
  logic            more_res;
  logic [7:0]      sat_val [3];
  logic [PrdW-1:0] shifted [3];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != sblur_pkg::SB_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective radius, clipped to the ring
  assign r_eff = (radius_r > 6'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : radius_r[RW-1:0];

  // Saturating fill count after this item
  assign seen_inc = (seen_r == CW'(RingDepth)) ? seen_r : seen_r + 1'b1;
  assign oldest   = seen_r - 1'b1;

  // First centre of the run: r for a plain pixel, clipped by the line on the last
  always_comb begin
    if (XW'(seen_inc) - 1'b1 > XW'(r_eff)) begin
      c_start = r_eff;
    end else begin
      c_start = RW'(seen_inc - 1'b1);
    end
  end

  assign start_res  = in_data.line_end || (XW'(seen_inc) > XW'(r_eff));
  assign sweep_done = (j_r == AW'({1'b0, r_eff, 1'b0} >> 0));
  assign more_res   = last_mode_r && (c_r != '0);

  // Window tap: age = c + r - j clamped to the current line, weight r+1-|j-r|
  always_comb begin
    cr_sum = XW'(c_r) + XW'(r_eff);
    if (cr_sum >= XW'(j_r)) begin
      age_raw = cr_sum - XW'(j_r);
    end else begin
      age_raw = '0;
    end
    if (age_raw > XW'(oldest)) begin
      age = AW'(oldest);
    end else begin
      age = age_raw[AW-1:0];
    end
    slot_sum = XW'(wpos_r) + XW'(RingDepth - 1) - XW'(age);
    if (slot_sum >= XW'(RingDepth)) begin
      rd_slot = AW'(slot_sum - XW'(RingDepth));
    end else begin
      rd_slot = slot_sum[AW-1:0];
    end
    if (j_r >= AW'(r_eff)) begin
      tap_off = j_r - AW'(r_eff);
    end else begin
      tap_off = AW'(r_eff) - j_r;
    end
    weight = WW'(XW'(r_eff) + 1'b1 - XW'(tap_off));
  end

  // Normalise and saturate
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      shifted[ch] = prod_r[ch] >> shift_r;
      if (shifted[ch] > PrdW'(sblur_pkg::BYTE_MAX)) begin
        sat_val[ch] = sblur_pkg::BYTE_MAX;
      end else begin
        sat_val[ch] = shifted[ch][7:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sblur_pkg::SB_IDLE: begin
        if (accept && start_res) begin
          state_nxt = sblur_pkg::SB_SWEEP;
        end
      end
      sblur_pkg::SB_SWEEP: begin
        if (sweep_done) begin
          state_nxt = sblur_pkg::SB_DRAIN;
        end
      end
      sblur_pkg::SB_DRAIN: state_nxt = sblur_pkg::SB_MUL;
      sblur_pkg::SB_MUL:   state_nxt = sblur_pkg::SB_EMIT;
      sblur_pkg::SB_EMIT: begin
        if (out_free) begin
          state_nxt = more_res ? sblur_pkg::SB_SWEEP : sblur_pkg::SB_IDLE;
        end
      end
      default: state_nxt = sblur_pkg::SB_IDLE;
    endcase
  end

  // Datapath and control values
  always_comb begin
    wpos_nxt      = wpos_r;
    seen_nxt      = seen_r;
    radius_nxt    = radius_r;
    mult_nxt      = mult_r;
    shift_nxt     = shift_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    last_mode_nxt = last_mode_r;
    alpha_nxt     = alpha_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rd_vld_nxt    = 1'b0;
    rd_w_nxt      = weight;
    rd_ctr_nxt    = (j_r == AW'(r_eff));
    out_valid_nxt = out_valid_r && out_stall;
    for (int ch = 0; ch < 3; ch++) begin
      acc_nxt[ch]  = acc_r[ch];
      prod_nxt[ch] = prod_r[ch];
    end

    // register writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sblur_pkg::CFG_RADIUS:     radius_nxt = cfg_wdata[5:0];
        sblur_pkg::CFG_NORM_MULT:  mult_nxt   = cfg_wdata[9:0];
        sblur_pkg::CFG_NORM_SHIFT: shift_nxt  = cfg_wdata[4:0];
        default: ;
      endcase
    end

    // accumulate the tap read last cycle
    if (rd_vld_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_nxt[ch] = acc_r[ch] + SumW'(rd_w_r) * SumW'(rdata_r[8*ch +: 8]);
      end
      if (rd_ctr_r) begin
        alpha_nxt = rdata_r[31:24];
      end
    end

    case (state_r)
      sblur_pkg::SB_IDLE: begin
        if (accept) begin
          mem_we        = 1'b1;
          wpos_nxt      = (wpos_r == AW'(RingDepth - 1)) ? '0 : wpos_r + 1'b1;
          seen_nxt      = seen_inc;
          last_mode_nxt = in_data.line_end;
          c_nxt         = c_start;
          j_nxt         = '0;
          for (int ch = 0; ch < 3; ch++) begin
            acc_nxt[ch] = '0;
          end
        end
      end
      sblur_pkg::SB_SWEEP: begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        j_nxt      = j_r + 1'b1;
      end
      sblur_pkg::SB_MUL: begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_nxt[ch] = PrdW'(acc_r[ch]) * PrdW'(mult_r);
        end
      end
      sblur_pkg::SB_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_red   = sat_val[0];
          out_data_nxt.out_green = sat_val[1];
          out_data_nxt.out_blue  = sat_val[2];
          out_data_nxt.out_alpha = alpha_r;
          out_data_nxt.run_last  = !more_res;
          out_data_nxt.line_last = last_mode_r && (c_r == '0);
          if (more_res) begin
            c_nxt = c_r - 1'b1;
            j_nxt = '0;
            for (int ch = 0; ch < 3; ch++) begin
              acc_nxt[ch] = '0;
            end
          end else if (last_mode_r) begin
            seen_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Ring memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wpos_r] <= {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};
    end
    if (mem_re) begin
      rdata_r <= ring_mem[rd_slot];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sblur_pkg::SB_IDLE;
      wpos_r      <= '0;
      seen_r      <= '0;
      radius_r    <= sblur_pkg::RADIUS_RST;
      mult_r      <= sblur_pkg::NORM_MULT_RST;
      shift_r     <= sblur_pkg::NORM_SHIFT_RST;
      last_mode_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wpos_r      <= wpos_nxt;
      seen_r      <= seen_nxt;
      radius_r    <= radius_nxt;
      mult_r      <= mult_nxt;
      shift_r     <= shift_nxt;
      last_mode_r <= last_mode_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    c_r        <= c_nxt;
    rd_w_r     <= rd_w_nxt;
    rd_ctr_r   <= rd_ctr_nxt;
    alpha_r    <= alpha_nxt;
    out_data_r <= out_data_nxt;
    for (int ch = 0; ch < 3; ch++) begin
      acc_r[ch]  <= acc_nxt[ch];
      prod_r[ch] <= prod_nxt[ch];
    end
  end

endmodule

`default_nettype wire
